>>> sv/shabc_pkg.sv
// shared types, constants and functions of the sha-256 block compressor
package shabc_pkg;

   typedef logic [31:0] word_type;
   typedef logic [5:0]  round_type;
   typedef logic [3:0]  count_type;

   localparam int unsigned NUM_VARS   = 8;
   localparam int unsigned NUM_SCHED  = 16;
   localparam round_type   LAST_ROUND = 6'd63;
   localparam count_type   LAST_WORD  = 4'd15;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ROUND = 3'b010,
      ST_DONE  = 3'b100
   } state_type;

   // control from the sequencer to the schedule and round units
   typedef struct packed {
      logic      load_word;
      logic      init;
      logic      step;
      round_type round;
   } ctrl_type;

   localparam word_type INIT_HASH [NUM_VARS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   // round constant rom
   function automatic word_type round_const(input round_type idx);
      word_type k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      round_const = k;
   endfunction

endpackage

>>> sv/shabc_sched.sv
// message schedule window: shift line of sixteen words with in-place expansion
module shabc_sched (
   input  logic                clock,
   input  shabc_pkg::ctrl_type ctrl,
   input  shabc_pkg::word_type msg_word,
   output shabc_pkg::word_type wt
);
   import shabc_pkg::*;

   word_type win_ff [NUM_SCHED];
   word_type win_in [NUM_SCHED];
   word_type expand_word;

   // next schedule word from the fixed taps of the window
   assign expand_word = win_ff[0] + small_sigma0(win_ff[1]) + win_ff[9]
                      + small_sigma1(win_ff[14]);

   assign wt = win_ff[0];

   // shift in either a message word or an expanded word
   always_comb begin
      for (int i = 0; i < NUM_SCHED - 1; i++) begin
         win_in[i] = win_ff[i + 1];
      end
      win_in[NUM_SCHED - 1] = ctrl.load_word ? msg_word : expand_word;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_word || ctrl.step) begin
         win_ff <= win_in;
      end
   end

endmodule

>>> sv/shabc_round.sv
// compression round unit: working variables and one round of logic reused 64 times
module shabc_round (
   input  logic                clock,
   input  shabc_pkg::ctrl_type ctrl,
   input  shabc_pkg::word_type wt,
   input  shabc_pkg::word_type chain [shabc_pkg::NUM_VARS],
   output shabc_pkg::word_type vars  [shabc_pkg::NUM_VARS]
);
   import shabc_pkg::*;

   word_type v_ff [NUM_VARS];
   word_type v_in [NUM_VARS];
   word_type t1;
   word_type t2;
   word_type ch;
   word_type maj;

   // one sha-256 round
   always_comb begin
      ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1  = v_ff[7] + big_sigma1(v_ff[4]) + ch + round_const(ctrl.round) + wt;
      t2  = big_sigma0(v_ff[0]) + maj;
      v_in[7] = v_ff[6];
      v_in[6] = v_ff[5];
      v_in[5] = v_ff[4];
      v_in[4] = v_ff[3] + t1;
      v_in[3] = v_ff[2];
      v_in[2] = v_ff[1];
      v_in[1] = v_ff[0];
      v_in[0] = t1 + t2;
   end

   // load from the chaining value at block start, then step once per round
   always_ff @(posedge clock) begin
      if (ctrl.init) begin
         v_ff <= chain;
      end else if (ctrl.step) begin
         v_ff <= v_in;
      end
   end

   assign vars = v_ff;

endmodule

>>> sv/sha256_block_compressor_unit.sv
// top level of the sha-256 block compressor: sequencer, chaining value and result register
//
// usage:
//   request channel: req_msg_word carries the next big-endian word of a padded message,
//   sixteen per 512-bit block; req_new_message marks a message's first word and reloads
//   the initial hash values (a partial block in progress is dropped).
//   response channel: after every sixteenth word one response carries the eight chaining
//   words rsp_digest_0..7; other words give no response.
// timing:
//   words 1..15 of a block are taken while req_stall is low. the sixteenth word starts 64 rounds on
//   the single shared round unit, one round per cycle, then the add cycle adds the result into
//   the chaining value, and rsp_valid rises at the end of the add cycle. req_stall is high
//   during the rounds and the add cycle.
// reset:
//   synchronous reset loads the initial hash values, clears the word count and drops
//   any pending response.
// stalls:
//   the response register holds while rsp_stall is high; words of the next block are
//   still taken, and the add cycle waits until the pending response is taken.
module sha256_block_compressor_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  shabc_pkg::word_type req_msg_word,
   input  logic                req_new_message,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output shabc_pkg::word_type rsp_digest_0,
   output shabc_pkg::word_type rsp_digest_1,
   output shabc_pkg::word_type rsp_digest_2,
   output shabc_pkg::word_type rsp_digest_3,
   output shabc_pkg::word_type rsp_digest_4,
   output shabc_pkg::word_type rsp_digest_5,
   output shabc_pkg::word_type rsp_digest_6,
   output shabc_pkg::word_type rsp_digest_7
);
   import shabc_pkg::*;

   state_type state_ff;
   state_type state_in;
   count_type count_ff;
   count_type count_in;
   round_type round_ff;
   round_type round_in;
   word_type  chain_ff [NUM_VARS];
   word_type  dig_ff   [NUM_VARS];
   word_type  vars     [NUM_VARS];
   word_type  sum      [NUM_VARS];
   word_type  wt;
   logic      rsp_valid_ff;
   logic      req_take;
   logic      blk_full;
   logic      out_free;
   logic      finish;
   ctrl_type  ctrl;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_DONE) && out_free;

   // word position: a new message restarts at word 0
   assign count_in = req_new_message ? count_type'(1) : count_ff + count_type'(1);
   assign blk_full = req_take && !req_new_message && (count_ff == LAST_WORD);

   // sequencer
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      case (state_ff)
         ST_IDLE: begin
            if (blk_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            round_in = round_ff + round_type'(1);
            if (round_ff == LAST_ROUND) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            round_in = '0;
         end
      endcase
   end

   // control bundle to the shared units
   always_comb begin
      ctrl.load_word = req_take;
      ctrl.init      = blk_full;
      ctrl.step      = (state_ff == ST_ROUND);
      ctrl.round     = round_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= INIT_HASH;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         if (req_take) begin
            count_ff <= count_in;
            if (req_new_message) begin
               chain_ff <= INIT_HASH;
            end
         end
         if (finish) begin
            chain_ff     <= sum;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // feed-forward add of the working variables
   always_comb begin
      for (int j = 0; j < NUM_VARS; j++) begin
         sum[j] = chain_ff[j] + vars[j];
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (finish) begin
         dig_ff <= sum;
      end
   end

   shabc_sched u_sched (
      .clock    (clock),
      .ctrl     (ctrl),
      .msg_word (req_msg_word),
      .wt       (wt)
   );

   shabc_round u_round (
      .clock (clock),
      .ctrl  (ctrl),
      .wt    (wt),
      .chain (chain_ff),
      .vars  (vars)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_digest_0 = dig_ff[0];
   assign rsp_digest_1 = dig_ff[1];
   assign rsp_digest_2 = dig_ff[2];
   assign rsp_digest_3 = dig_ff[3];
   assign rsp_digest_4 = dig_ff[4];
   assign rsp_digest_5 = dig_ff[5];
   assign rsp_digest_6 = dig_ff[6];
   assign rsp_digest_7 = dig_ff[7];

`ifndef SYNTH
   // a full block always starts the rounds
   a_blk_starts: assert property (@(posedge clock) disable iff (reset)
      blk_full |=> (state_ff == ST_ROUND) && (round_ff == '0))
      else $error("block did not start rounds");

   // round counter rests at zero outside the rounds
   a_round_rest: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ROUND) |-> (round_ff == '0))
      else $error("round counter nonzero while not running");

   // a new response only follows the add cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response without a finished block");

   // no word is taken while rounds run
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> !req_take)
      else $error("word taken during rounds");
`endif

endmodule

>>> dv/testbench.sv
// self-checking testbench for the sha-256 block compressor unit
module testbench;
   import shabc_pkg::*;

   typedef logic [0:7][31:0]  digest_type;
   typedef logic [0:15][31:0] block_type;

   typedef struct {
      word_type   msg_word;
      logic       restart;
      logic       known;
      digest_type digest;
   } row_type;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned RANDOM_WORDS = 1800;
   localparam int unsigned DRAIN_CYCLES = 100;

   localparam word_type SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   logic     clock;
   logic     reset           = 1'b1;
   logic     req_valid       = 1'b0;
   logic     req_stall;
   word_type req_msg_word    = '0;
   logic     req_new_message = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall       = 1'b0;
   word_type rsp_digest_0, rsp_digest_1, rsp_digest_2, rsp_digest_3;
   word_type rsp_digest_4, rsp_digest_5, rsp_digest_6, rsp_digest_7;

   // predictor state: chaining value, words of the current block, position in it
   digest_type chain_val;
   block_type  blk_words;
   count_type  blk_pos = '0;

   row_type     rows [$];
   digest_type  digest_q [$];
   int unsigned digest_count = 0;
   int unsigned bad_digests  = 0;
   int unsigned cycle_count  = 0;
   logic        gap_quiet    = 1'b0;

   sha256_block_compressor_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_msg_word    (req_msg_word),
      .req_new_message (req_new_message),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_0    (rsp_digest_0),
      .rsp_digest_1    (rsp_digest_1),
      .rsp_digest_2    (rsp_digest_2),
      .rsp_digest_3    (rsp_digest_3),
      .rsp_digest_4    (rsp_digest_4),
      .rsp_digest_5    (rsp_digest_5),
      .rsp_digest_6    (rsp_digest_6),
      .rsp_digest_7    (rsp_digest_7)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic word_type ror32(input word_type x, input int unsigned n);
      logic [63:0] both;
      both = {x, x} >> n;
      return both[31:0];
   endfunction

   // one 512-bit block through schedule expansion and 64 rounds
   function automatic digest_type compress(input digest_type hv, input block_type blk);
      word_type   sched [64];
      word_type   v [8];
      word_type   s0, s1, t1, t2;
      digest_type nv;
      for (int i = 0; i < 16; i++) sched[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
      end
      for (int j = 0; j < 8; j++) v[j] = hv[j];
      for (int i = 0; i < 64; i++) begin
         s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
         t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + sched[i];
         s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
         t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) nv[j] = hv[j] + v[j];
      return nv;
   endfunction

   // append one directed row to the stimulus table
   function automatic void add_row(input word_type w, input logic restart,
                                   input logic known, input digest_type digest);
      row_type r;
      r.msg_word = w;
      r.restart  = restart;
      r.known    = known;
      r.digest   = digest;
      rows.insert(rows.size(), r);
   endfunction

   // append one expected digest to the scoreboard
   function automatic void expect_digest(input digest_type d);
      digest_q.insert(digest_q.size(), d);
   endfunction

   // take one accepted word into the predictor; flags a completed block
   task automatic absorb_word(input word_type w, input logic restart, output logic blk_done);
      if (restart) begin
         for (int j = 0; j < 8; j++) chain_val[j] = SHA_IV[j];
         blk_pos = '0;
      end
      blk_words[blk_pos] = w;
      blk_pos = blk_pos + 1'b1;
      blk_done = (blk_pos == '0);
      if (blk_done) chain_val = compress(chain_val, blk_words);
   endtask

   // offer one request and wait for it to be taken
   task automatic send_word(input word_type w, input logic restart, output logic blk_done);
      req_valid       <= 1'b1;
      req_msg_word    <= w;
      req_new_message <= restart;
      do @(posedge clock); while (req_stall);
      absorb_word(w, restart, blk_done);
   endtask

   // random idle between requests: mostly short, a few long
   task automatic idle_gap();
      int unsigned n;
      n = 0;
      if (!gap_quiet) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: n = 0;
            9:             n = $urandom_range(15, 80);
            default:       n = $urandom_range(1, 3);
         endcase
      end
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic word_type pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // stimulus: directed rows, then random messages
   initial begin : stimulus
      logic        blk_done;
      logic        restart;
      word_type    w;
      int unsigned pos;
      logic        paused;

      for (int j = 0; j < 8; j++) chain_val[j] = SHA_IV[j];
      paused = 1'b0;

      // "abc" block right after reset with no flag: reset alone loads the initial hash
      add_row(32'h61626380, 1'b0, 1'b0, '0);
      for (int i = 0; i < 14; i++) add_row(32'h00000000, 1'b0, 1'b0, '0);
      add_row(32'h00000018, 1'b0, 1'b1,
              {32'hba7816bf, 32'h8f01cfea, 32'h414140de, 32'h5dae2223,
               32'hb00361a3, 32'h96177a9c, 32'hb410ff61, 32'hf20015ad});
      // partial block of extreme words, then a flag mid-block drops it
      add_row(32'hffffffff, 1'b0, 1'b0, '0);
      add_row(32'h00000000, 1'b0, 1'b0, '0);
      add_row(32'hffffffff, 1'b0, 1'b0, '0);
      add_row(32'h80000001, 1'b0, 1'b0, '0);
      add_row(32'hffffffff, 1'b1, 1'b0, '0);

      while (reset) @(posedge clock);

      foreach (rows[i]) begin
         send_word(rows[i].msg_word, rows[i].restart, blk_done);
         if (blk_done) expect_digest(rows[i].known ? rows[i].digest : chain_val);
         idle_gap();
      end

      // random messages: mostly whole blocks, some chained, a few broken by a flag
      pos = 1;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 64 == 0) gap_quiet = ($urandom_range(0, 3) == 0);
         if (pos == 0) restart = ($urandom_range(0, 3) == 0);
         else restart = ($urandom_range(0, 49) == 0);
         w = pick_word();
         send_word(w, restart, blk_done);
         if (blk_done) expect_digest(chain_val);
         pos = restart ? 1 : (pos + 1) % 16;
         if (!paused && n >= 900 && pos == 0) begin
            // let every pending response drain before the next request
            paused = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (digest_q.size() != 0) @(posedge clock);
         end else begin
            idle_gap();
         end
      end

      // drain and verdict
      req_valid <= 1'b0;
      @(posedge clock);
      while (digest_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_digests == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   // response stall: random phases, plus one long hold-off that backs up requests
   initial begin : stall_drive
      int unsigned stall_left;
      int unsigned stall_pct;
      int unsigned phase_cycles;
      logic        held;
      stall_left   = 0;
      stall_pct    = 0;
      phase_cycles = 0;
      held         = 1'b0;
      forever begin
         @(posedge clock);
         if (phase_cycles == 0) begin
            phase_cycles = 200;
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 10;
               default: stall_pct = 40;
            endcase
         end
         phase_cycles--;
         if (!held && digest_count >= 12) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
                                                     : $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each taken response with the oldest expected digest
   always @(posedge clock) begin : digest_check
      digest_type want;
      digest_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         digest_count++;
         got = {rsp_digest_0, rsp_digest_1, rsp_digest_2, rsp_digest_3,
                rsp_digest_4, rsp_digest_5, rsp_digest_6, rsp_digest_7};
         if (digest_q.size() == 0) begin
            $error("unexpected response, rsp_digest_0 %h", got[0]);
            bad_digests++;
         end else begin
            want = digest_q.pop_front();
            for (int j = 0; j < 8; j++) begin
               if (got[j] !== want[j]) begin
                  $error("rsp_digest_%0d: expected %h, got %h", j, want[j], got[j]);
                  bad_digests++;
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

>>> filelist.f
sv/shabc_pkg.sv
sv/shabc_sched.sv
sv/shabc_round.sv
sv/sha256_block_compressor_unit.sv
dv/testbench.sv
